>>> rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/c3dc_pkg.sv
package c3dc_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);

  // Fixed field widths
  localparam int PIX_W  = 8;
  localparam int COEF_W = 8;
  localparam int ROW_W  = 24;
  localparam int DIV_W  = 10;
  localparam int IW_W   = 11;
  localparam int IH_W   = 16;
  localparam int IDX_W  = 3;

  // Weighted sum: 9 * 255 * 128 needs 19 magnitude bits plus sign and margin
  localparam int PROD_W = PIX_W + 1 + COEF_W;
  localparam int ACC_W  = 21;
  localparam int QUO_W  = 19;
  localparam int TAPS   = 9;
  localparam int CNT_W  = 5;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_COEF_ROW0    = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_ROW1    = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_ROW2    = 3'd2;
  localparam logic [IDX_W-1:0] REG_DIVISOR      = 3'd3;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

  typedef struct packed {
    logic [ROW_W-1:0] coef_row0;
    logic [ROW_W-1:0] coef_row1;
    logic [ROW_W-1:0] coef_row2;
    logic [DIV_W-1:0] divisor;
    logic [IW_W-1:0]  image_width;
    logic [IH_W-1:0]  image_height;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic       accept;
    logic       shift;
    logic       mac_mul;
    logic       mac_add;
    logic [3:0] mac_idx;
    logic       div_load;
    logic       div_step;
    logic       load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic interior;
    logic neg;
    logic out_free;
  } sts_t;

  // Pick the signed coefficient of one tap, row-major
  function automatic logic signed [COEF_W-1:0] coef_at(cfg_t cfg, logic [3:0] idx);
    logic signed [COEF_W-1:0] c;
    c = '0;
    unique case (idx)
      4'd0:    c = cfg.coef_row0[7:0];
      4'd1:    c = cfg.coef_row0[15:8];
      4'd2:    c = cfg.coef_row0[23:16];
      4'd3:    c = cfg.coef_row1[7:0];
      4'd4:    c = cfg.coef_row1[15:8];
      4'd5:    c = cfg.coef_row1[23:16];
      4'd6:    c = cfg.coef_row2[7:0];
      4'd7:    c = cfg.coef_row2[15:8];
      4'd8:    c = cfg.coef_row2[23:16];
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/conv3x3_divide_clamp.sv
// Channel   Direction  Data                        Side band
// in_       slave      tdata[7:0] = pixel_in       -
// out_      master     tdata[7:0] = pixel_out      tlast = frame_last
// cfg_      slave      index[2:0], data[23:0]      -
//
// A border pixel is accepted and then written to the line stores. An interior
// pixel also goes through the multiply-accumulate steps, a divider load, the
// divider steps and the output load; a negative weighted sum skips the divider
// steps. A new pixel is taken while a result waits in the output register; the
// next result waits until that one is taken.
// Reset (rst_n low, synchronous) clears counters and loads register defaults.
module conv3x3_divide_clamp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] pixel_out
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import c3dc_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_row0    <= ROW_W'(0);
      cfg_r.coef_row1    <= ROW_W'(256);
      cfg_r.coef_row2    <= ROW_W'(0);
      cfg_r.divisor      <= DIV_W'(1);
      cfg_r.image_width  <= IW_W'(1024);
      cfg_r.image_height <= IH_W'(768);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COEF_ROW0:    cfg_r.coef_row0    <= cfg_data;
        REG_COEF_ROW1:    cfg_r.coef_row1    <= cfg_data;
        REG_COEF_ROW2:    cfg_r.coef_row2    <= cfg_data;
        REG_DIVISOR:      cfg_r.divisor      <= cfg_data[DIV_W-1:0];
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data[IW_W-1:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data[IH_W-1:0];
        default: ;
      endcase
    end
  end

  c3dc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  c3dc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .sts        (sts),
    .pixel_in   (in_tdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .pixel_out  (out_tdata),
    .frame_last (out_tlast)
  );

endmodule

>>> rtl/core/c3dc_ctrl.sv
module c3dc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  c3dc_pkg::sts_t  sts,
  output c3dc_pkg::cmd_t  cmd
);
  import c3dc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(TAPS);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Sequence one request through shift, multiply-accumulate, divide and output
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.mac_idx  = cnt_r[3:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.interior ? S_MAC : S_IDLE;
      end
      S_MAC: begin
        cmd.mac_mul = (cnt_r < MAC_LAST);
        cmd.mac_add = (cnt_r != '0);
        if (cnt_r == MAC_LAST) begin
          state_nxt = S_PREP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_PREP: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = sts.neg ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/c3dc_dp.sv
module c3dc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  c3dc_pkg::cfg_t                cfg,
  input  c3dc_pkg::cmd_t                cmd,
  output c3dc_pkg::sts_t                sts,
  input  logic [c3dc_pkg::PIX_W-1:0]    pixel_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [c3dc_pkg::PIX_W-1:0]    pixel_out,
  output logic                          frame_last
);
  import c3dc_pkg::*;

  localparam logic [IW_W-1:0] MAX_W_L = IW_W'(MAX_WIDTH);
  localparam logic [IW_W-1:0] MIN_W_L = IW_W'(3);
  localparam logic [IH_W-1:0] MIN_H_L = IH_W'(3);

  // Line stores
  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];

  logic [PIX_W-1:0]  pix_r, rd_upper_r, rd_lower_r;
  logic [PIX_W-1:0]  win_r [TAPS];
  logic [ADDR_W-1:0] col_r;
  logic [IH_W-1:0]   row_r;
  logic              last_r;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [DIV_W-1:0]         rem_r;
  logic [QUO_W-1:0]         quo_r;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_last_r;

  logic [IW_W-1:0]   eff_w;
  logic [IH_W-1:0]   eff_h;
  logic [DIV_W-1:0]  eff_d;
  logic [IW_W-1:0]   col_ext, col_inc;
  logic [IH_W:0]     row_inc;
  logic              is_last;

  // Effective geometry and divisor
  always_comb begin
    eff_w = cfg.image_width;
    if (cfg.image_width < MIN_W_L) eff_w = MIN_W_L;
    if (cfg.image_width > MAX_W_L) eff_w = MAX_W_L;
    eff_h = (cfg.image_height < MIN_H_L) ? MIN_H_L : cfg.image_height;
    eff_d = (cfg.divisor == '0) ? DIV_W'(1) : cfg.divisor;
  end

  assign col_ext = IW_W'(col_r);
  assign col_inc = col_ext + 1'b1;
  assign row_inc = {1'b0, row_r} + 1'b1;
  assign is_last = (row_inc[IH_W-1:0] == eff_h) && (col_inc == eff_w);

  assign sts.interior = (row_r >= IH_W'(2)) && (col_ext >= IW_W'(2)) &&
                        (row_r < eff_h) && (col_ext < eff_w);
  assign sts.neg      = acc_r[ACC_W-1];
  assign sts.out_free = !out_valid_r || out_ready;

  // Capture the sample and read both line stores at the current column
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r      <= pixel_in;
      rd_upper_r <= upper_mem[col_r];
      rd_lower_r <= lower_mem[col_r];
    end
    if (cmd.shift) begin
      upper_mem[col_r] <= rd_lower_r;
      lower_mem[col_r] <= pix_r;
    end
  end

  // Shift the window one column left and load the new column
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= rd_upper_r;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= rd_lower_r;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= pix_r;
      last_r   <= is_last;
    end
  end

  // Advance column and row counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.shift) begin
      if (col_inc >= eff_w) begin
        col_r <= '0;
        row_r <= (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[IH_W-1:0];
      end else begin
        col_r <= col_inc[ADDR_W-1:0];
      end
    end
  end

  // Select one window tap for the multiplier
  logic [PIX_W-1:0] tap_pix;
  always_comb begin
    tap_pix = '0;
    unique case (cmd.mac_idx)
      4'd0:    tap_pix = win_r[0];
      4'd1:    tap_pix = win_r[1];
      4'd2:    tap_pix = win_r[2];
      4'd3:    tap_pix = win_r[3];
      4'd4:    tap_pix = win_r[4];
      4'd5:    tap_pix = win_r[5];
      4'd6:    tap_pix = win_r[6];
      4'd7:    tap_pix = win_r[7];
      4'd8:    tap_pix = win_r[8];
      default: tap_pix = '0;
    endcase
  end

  // Multiply one tap per cycle, accumulate the previous product
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      acc_r <= '0;
    end else if (cmd.mac_add) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (cmd.mac_mul) begin
      prod_r <= $signed({1'b0, tap_pix}) * coef_at(cfg, cmd.mac_idx);
    end
  end

  // Restoring divide of the non-negative sum, one quotient bit per cycle
  logic [DIV_W:0] trial;
  assign trial = {rem_r, quo_r[QUO_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= '0;
      quo_r <= acc_r[QUO_W-1:0];
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, eff_d}) begin
        rem_r <= DIV_W'(trial - {1'b0, eff_d});
        quo_r <= {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DIV_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], 1'b0};
      end
    end
  end

  // Clamp into the output register; hold it until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (acc_r[ACC_W-1]) begin
        out_pix_r <= '0;
      end else if (|quo_r[QUO_W-1:PIX_W]) begin
        out_pix_r <= '1;
      end else begin
        out_pix_r <= quo_r[PIX_W-1:0];
      end
      out_last_r <= last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign pixel_out  = out_pix_r;
  assign frame_last = out_last_r;

endmodule

>>> rtl/core/c3dc_checker.sv
`include "assert_macros.svh"

module c3dc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  // Hold a stalled result
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped")

  // Keep a stalled payload steady
  `ASSERT_NXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast), "stalled payload changed")

  // Drop ready for the cycle after a request is taken
  `ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready, "second request taken too early")

  // A result never shows up the cycle right after a request
  `ASSERT_IMP(a_no_instant_result, clk, rst_n, $rose(out_tvalid), !$past(in_tvalid && in_tready), "result appeared too early")

endmodule

bind conv3x3_divide_clamp c3dc_checker u_c3dc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> dv/conv_result_checker.sv
module conv_result_checker
  import c3dc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [PIX_W-1:0]  in_tdata,   // [7:0] pixel_in
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [PIX_W-1:0]  out_tdata,  // [7:0] pixel_out
  input  logic              out_tlast,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [ROW_W-1:0]  cfg_data,
  output int                mismatches,
  output int                outstanding,
  output int                compared
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } plane_result_t;

  // Shadow of the register file and the neighborhood state
  cfg_t             regs;
  logic [PIX_W-1:0] upper_row [MAX_WIDTH];
  logic [PIX_W-1:0] lower_row [MAX_WIDTH];
  logic [PIX_W-1:0] win [TAPS];
  int unsigned      col_cnt;
  int unsigned      row_cnt;
  plane_result_t    filtered_q [$];

  // Advance the window by one sample; queue the filtered value of an interior pixel
  function automatic void take_pixel(logic [PIX_W-1:0] pix);
    int unsigned              w, h, c, r;
    int                       i, j, sum, d;
    logic [PIX_W-1:0]         top_px, mid_px;
    logic [ROW_W-1:0]         krow;
    logic signed [COEF_W-1:0] cf;
    plane_result_t            res;
    w = regs.image_width;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = regs.image_height;
    if (h < 3) h = 3;
    c = col_cnt;
    r = row_cnt;
    top_px = '0;
    mid_px = '0;
    if (c < MAX_WIDTH) begin
      top_px = upper_row[c];
      mid_px = lower_row[c];
      upper_row[c] = mid_px;
      lower_row[c] = pix;
    end
    // shift columns left, new column enters on the right
    for (i = 0; i < 3; i++) begin
      win[3*i]   = win[3*i+1];
      win[3*i+1] = win[3*i+2];
    end
    win[2] = top_px;
    win[5] = mid_px;
    win[8] = pix;
    if (r >= 2 && c >= 2 && r < h && c < w) begin
      sum = 0;
      for (i = 0; i < 3; i++) begin
        case (i)
          0:       krow = regs.coef_row0;
          1:       krow = regs.coef_row1;
          default: krow = regs.coef_row2;
        endcase
        for (j = 0; j < 3; j++) begin
          cf = krow[8*j +: 8];
          sum += int'(win[3*i+j]) * int'(cf);
        end
      end
      // zero divisor acts as one; division truncates toward zero
      d = (regs.divisor == '0) ? 1 : int'(regs.divisor);
      sum = sum / d;
      if (sum < 0) sum = 0;
      else if (sum > 255) sum = 255;
      res.pix  = sum[PIX_W-1:0];
      res.last = (r == h - 1) && (c == w - 1);
      filtered_q.push_back(res);
    end
    // wrap column, then row, at the effective frame size
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  // Follow every request on the three channels
  always @(posedge clk) begin : track
    int            i;
    plane_result_t head;
    if (!rst_n) begin
      regs.coef_row0    = '0;
      regs.coef_row1    = 24'h000100;
      regs.coef_row2    = '0;
      regs.divisor      = 10'd1;
      regs.image_width  = 11'd1024;
      regs.image_height = 16'd768;
      for (i = 0; i < MAX_WIDTH; i++) begin
        upper_row[i] = '0;
        lower_row[i] = '0;
      end
      for (i = 0; i < TAPS; i++) win[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      filtered_q.delete();
      mismatches = 0;
      compared = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COEF_ROW0:    regs.coef_row0    = cfg_data;
          REG_COEF_ROW1:    regs.coef_row1    = cfg_data;
          REG_COEF_ROW2:    regs.coef_row2    = cfg_data;
          REG_DIVISOR:      regs.divisor      = cfg_data[DIV_W-1:0];
          REG_IMAGE_WIDTH:  regs.image_width  = cfg_data[IW_W-1:0];
          REG_IMAGE_HEIGHT: regs.image_height = cfg_data[IH_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) take_pixel(in_tdata);
      // compare each result with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (filtered_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result: pixel_out %0d frame_last %0b",
                                    out_tdata, out_tlast));
        end else begin
          head = filtered_q.pop_front();
          compared++;
          if (out_tdata !== head.pix || out_tlast !== head.last) begin
            report_mismatch($sformatf(
              "result %0d: pixel_out exp %0d got %0d, frame_last exp %0b got %0b",
              compared, head.pix, out_tdata, head.last, out_tlast));
          end
        end
      end
    end
    outstanding = filtered_q.size();
  end

endmodule

>>> dv/conv3x3_divide_clamp_test.sv
module conv3x3_divide_clamp_test;
  import c3dc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 80;
  localparam int IDLE_LIMIT      = 4000;
  localparam int RANDOM_PIXELS   = 1020;

  localparam logic [IDX_W-1:0] REG_ORDER [6] = '{REG_COEF_ROW0, REG_COEF_ROW1,
    REG_COEF_ROW2, REG_DIVISOR, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT};
  localparam logic [PIX_W-1:0] CHECKER_PIX [12] = '{8'd0, 8'd255, 8'd0, 8'd255,
    8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd17, 8'd200, 8'd3};

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [PIX_W-1:0] in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [PIX_W-1:0] out_tdata;
  logic             out_tlast;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [ROW_W-1:0] cfg_data;

  int               mismatches;
  int               outstanding;
  int               compared;
  int               idle_cycles;
  int               pixels_sent;
  int               settings;
  int               hold_offs;
  int               hold_off_reqs;
  bit               gaps_on;
  int unsigned      wide_raw;
  int unsigned      high_raw;
  logic [ROW_W-1:0] cfg_vals [6];

  conv3x3_divide_clamp DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  conv_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // End the run when no request completes for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: %0d cycles without a request, %0d results outstanding",
               idle_cycles, outstanding);
      $display("FAIL conv3x3_divide_clamp");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random ready pattern, plus a long hold-off on demand
  initial begin : sink
    int run;
    int r;
    bit level;
    out_tready = 1'b0;
    level = 1'b0;
    run = 0;
    forever begin
      @(posedge clk);
      if (hold_offs != hold_off_reqs) begin
        hold_offs++;
        level = 1'b0;
        run = HOLD_OFF_CYCLES;
      end else if (run > 0) begin
        run--;
      end else begin
        level = !level;
        r = $urandom_range(0, 99);
        if (level) run = (r < 70) ? $urandom_range(1, 8) :
                         (r < 90) ? $urandom_range(9, 40) : $urandom_range(100, 300);
        else       run = (r < 75) ? $urandom_range(1, 3) :
                         (r < 95) ? $urandom_range(4, 12) : $urandom_range(20, 60);
      end
      out_tready <= level;
    end
  end

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // Samples in one plane at the saturated geometry last written
  function automatic int frame_len();
    int unsigned w, h;
    w = wide_raw;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = (high_raw < 3) ? 3 : high_raw;
    return w * h;
  endfunction

  // Offer one sample, with an optional idle gap in front
  task automatic push_pixel(input logic [PIX_W-1:0] px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
  endtask

  // Drain the block, then write the selected registers from cfg_vals
  task automatic write_regs(input bit [5:0] mask);
    int i;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (i = 0; i < 6; i++) begin
      if (mask[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= REG_ORDER[i];
        cfg_data  <= cfg_vals[i];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
      end
    end
    cfg_valid <= 1'b0;
    if (mask[4]) wide_raw = cfg_vals[4][IW_W-1:0];
    if (mask[5]) high_raw = cfg_vals[5][IH_W-1:0];
    settings++;
  endtask

  // Choose a kernel and divisor: smoothing, sharpening, raw random or extremes
  task automatic pick_kernel();
    logic [COEF_W-1:0] cf [TAPS];
    int                i, sum, divv;
    case ($urandom_range(0, 3))
      0: begin
        sum = 0;
        for (i = 0; i < TAPS; i++) begin
          cf[i] = COEF_W'($urandom_range(0, 8));
          sum += int'(cf[i]);
        end
        divv = sum + $urandom_range(0, 3);
        if (divv == 0) divv = 1;
      end
      1: begin
        for (i = 0; i < TAPS; i++) cf[i] = COEF_W'(0 - int'($urandom_range(0, 2)));
        cf[4] = COEF_W'($urandom_range(1, 16));
        divv = $urandom_range(1, 4);
      end
      2: begin
        for (i = 0; i < TAPS; i++) cf[i] = COEF_W'($urandom_range(0, 255));
        divv = $urandom_range(0, 1023);
      end
      default: begin
        for (i = 0; i < TAPS; i++) begin
          case ($urandom_range(0, 4))
            0:       cf[i] = 8'h80;
            1:       cf[i] = 8'h7F;
            2:       cf[i] = 8'hFF;
            3:       cf[i] = 8'h01;
            default: cf[i] = 8'h00;
          endcase
        end
        divv = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(1, 1023);
      end
    endcase
    for (i = 0; i < 3; i++) cfg_vals[i] = {cf[3*i+2], cf[3*i+1], cf[3*i]};
    cfg_vals[3] = ROW_W'(divv);
  endtask

  initial begin : stimulus
    int  i, n, r, random_sent;
    bit  first;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_COEF_ROW0;
    cfg_data      = '0;
    hold_off_reqs = 0;
    gaps_on       = 1'b0;
    wide_raw      = 1024;
    high_raw      = 768;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Saturating kernel on white; zero divisor, width and height below range
    cfg_vals = '{24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 24'd0, 24'd0, 24'd1};
    write_regs(6'h3F);
    repeat (9) push_pixel(8'hFF);

    // Identity kernel on a checkerboard, tallest height, two interior rows
    cfg_vals = '{24'h000000, 24'h000100, 24'h000000, 24'd1, 24'd3, 24'd65535};
    write_regs(6'h3F);
    for (i = 0; i < 12; i++) push_pixel(CHECKER_PIX[i]);

    // Shrink height mid-frame past the row counter; next row wraps to the top
    cfg_vals = '{24'h808080, 24'h808080, 24'h808080, 24'd1023, 24'd3, 24'd3};
    write_regs(6'b101111);
    repeat (3) push_pixel(pick_pixel());

    // Random settings, each followed by one to three whole planes
    random_sent = 0;
    first = 1'b1;
    while (random_sent < RANDOM_PIXELS) begin
      pick_kernel();
      r = $urandom_range(0, 99);
      cfg_vals[4] = (r < 8)  ? ROW_W'($urandom_range(0, 2)) :
                    (r < 75) ? ROW_W'($urandom_range(3, 10)) :
                    (r < 93) ? ROW_W'($urandom_range(11, 32)) : ROW_W'($urandom_range(33, 80));
      r = $urandom_range(0, 99);
      cfg_vals[5] = (r < 8)  ? ROW_W'($urandom_range(0, 2)) :
                    (r < 85) ? ROW_W'($urandom_range(3, 6)) : ROW_W'($urandom_range(7, 16));
      if (first) begin
        cfg_vals[4] = ROW_W'($urandom_range(8, 16));
        cfg_vals[5] = ROW_W'($urandom_range(4, 6));
      end
      write_regs(first ? 6'h3F : 6'($urandom_range(1, 63)));
      gaps_on = ($urandom_range(0, 4) != 0);
      // back up the result side while samples keep coming
      if (first || $urandom_range(0, 9) == 0) hold_off_reqs++;
      first = 1'b0;
      repeat ($urandom_range(1, 3)) begin
        n = frame_len();
        repeat (n) push_pixel(pick_pixel());
        random_sent += n;
      end
    end

    // Wait for the last results, then let the pipeline settle
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples under %0d register settings; %0d filtered pixels compared.",
             pixels_sent, settings, compared);
    $display("Widths 3 to 80 incl. values below range, heights up to 65535, %0d long stalls.",
             hold_offs);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS conv3x3_divide_clamp");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, outstanding);
      $display("FAIL conv3x3_divide_clamp");
    end
    $finish;
  end

endmodule
